// ----- rtl/core/loop_trace_profiler_top_macros.svh -----
// ----------------------------------------------------------------------------
// Loop trace profiler assertion macros
// Shared wrappers for concurrent checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef LOOP_TRACE_PROFILER_TOP_MACROS_SVH
`define LOOP_TRACE_PROFILER_TOP_MACROS_SVH

// same-cycle implication
`define LTP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("loop trace profiler check failed");

// next-cycle implication
`define LTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("loop trace profiler check failed");

`endif

// ----- rtl/core/ltp_pkg.sv -----
// ----------------------------------------------------------------------------
// Loop trace profiler package
// Sizes, request/result types, command/status bundles, counter helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ltp_pkg;

	localparam int FRAGMENTS    = 256;
	localparam int SLOT_W       = $clog2(FRAGMENTS);
	localparam int USED_W       = SLOT_W + 1;
	localparam int HIST_JUMPS   = 8;
	localparam int HIST_DEPTH   = HIST_JUMPS + 1;
	localparam int POS_W        = 4;
	localparam int RSEL_W       = $clog2(HIST_JUMPS);
	localparam int PAT_W        = 8;
	localparam int POOL_ENTRIES = 32768;
	localparam int POOL_IDX_W   = $clog2(POOL_ENTRIES);
	localparam int POOL_NEXT_W  = POOL_IDX_W + 1;
	localparam int COUNT_BITS   = 32;

	localparam logic OP_JUMP = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_TABLE_FULL = 2'd1,
		ST_POOL_FULL  = 2'd2,
		ST_NOT_FOUND  = 2'd3
	} status_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] from_pc;
		logic [31:0] to_pc;
		logic [31:0] query_pc;
		logic [3:0]  query_jumps;
		logic [7:0]  query_pattern;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic        loop_found;
		logic [3:0]  loop_jumps;
		logic [7:0]  loop_pattern;
		logic [31:0] count;
		logic [7:0]  fragment_slot;
	} res_t;

	typedef struct packed {
		logic    load;
		logic    scan;
		logic    create;
		logic    meta;
		logic    zero_wr;
		logic    zero_res;
		logic    use_base;
		logic    alloc;
		logic    clear;
		logic    cnt_rd;
		logic    cnt_wr;
		logic    cnt_res;
		logic    shift;
		logic    finish;
		logic    set_status;
		status_t status_code;
	} cmd_t;

	typedef struct packed {
		logic op_read;
		logic hit;
		logic miss;
		logic full;
		logic loop_hit;
		logic pos_zero;
		logic q_zero;
		logic q_bad;
		logic region_valid;
		logic can_alloc;
		logic clear_last;
		logic out_free;
	} sts_t;

	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

endpackage

// ----- rtl/core/ltp_dp.sv -----
// ----------------------------------------------------------------------------
// Loop trace profiler datapath
// Fragment table, counters, region pool, histories and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltp_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  ltp_pkg::req_t  req,
	input  ltp_pkg::cmd_t  cmd,
	output ltp_pkg::sts_t  sts,
	output logic           res_valid,
	input  logic           res_stall,
	output ltp_pkg::res_t  res
);

	localparam int SW  = ltp_pkg::SLOT_W;
	localparam int UW  = ltp_pkg::USED_W;
	localparam int CB  = ltp_pkg::COUNT_BITS;
	localparam int PIW = ltp_pkg::POOL_IDX_W;
	localparam int PNW = ltp_pkg::POOL_NEXT_W;
	localparam int HD  = ltp_pkg::HIST_DEPTH;
	localparam int HJ  = ltp_pkg::HIST_JUMPS;
	localparam int PW  = ltp_pkg::PAT_W;
	localparam int QW  = ltp_pkg::POS_W;
	localparam int RW  = ltp_pkg::RSEL_W;

	// memories
	logic [31:0]   fa_mem   [ltp_pkg::FRAGMENTS];
	logic [CB-1:0] zc_mem   [ltp_pkg::FRAGMENTS];
	logic [HJ-1:0] vrow_mem [ltp_pkg::FRAGMENTS];
	logic [PIW-1:0] base_mem [ltp_pkg::FRAGMENTS * HJ];
	logic [CB-1:0] pc_mem   [ltp_pkg::POOL_ENTRIES];

	ltp_pkg::req_t  req_q;
	ltp_pkg::res_t  res_q;
	ltp_pkg::res_t  res_out_q;
	logic           res_valid_q;
	logic [UW-1:0]  used_q;
	logic [PNW-1:0] pool_next_q;
	logic [UW-1:0]  scan_q;
	logic           cmp_v_q;
	logic [SW-1:0]  cmp_idx_q;
	logic [31:0]    fa_rd_q;
	logic [SW-1:0]  slot_q;
	logic [SW-1:0]  hs_q [HD];
	logic [HD-1:0]  hv_q;
	logic [HJ-1:0]  br_q;
	logic [CB-1:0]  zc_rd_q;
	logic [HJ-1:0]  vrow_rd_q;
	logic [PIW-1:0] base_rd_q;
	logic [PIW-1:0] base_q;
	logic [PW-1:0]  clr_q;
	logic [CB-1:0]  pc_rd_q;

	logic [31:0]    key;
	logic           op_read;
	logic           pos_hit;
	logic [QW-1:0]  pos;
	logic [QW-1:0]  n_sel;
	logic [RW-1:0]  rsel;
	logic [PW-1:0]  pat_mask;
	logic [PW-1:0]  br_idx;
	logic [PW-1:0]  cnt_idx;
	logic [PNW:0]   size_w;
	logic [PIW-1:0] cnt_addr;
	logic [PIW-1:0] clr_addr;
	logic           branch;
	logic [CB-1:0]  zc_bump;
	logic [CB-1:0]  pc_bump;

	assign op_read = (req_q.operation == ltp_pkg::OP_READ);
	assign key     = op_read ? req_q.query_pc : req_q.to_pc;
	assign branch  = (req_q.to_pc != req_q.from_pc + 32'd4);

	// first match, newest first
	always_comb begin
		pos_hit = 1'b0;
		pos     = '0;
		for (int i = HD - 1; i >= 0; i--) begin
			if (hv_q[i] && hs_q[i] == slot_q) begin
				pos_hit = 1'b1;
				pos     = QW'(i);
			end
		end
	end

	assign n_sel    = op_read ? req_q.query_jumps : pos;
	assign rsel     = RW'(n_sel - 1'b1);
	assign pat_mask = PW'(({{PW{1'b0}}, 1'b1} << pos) - 1'b1);
	assign br_idx   = PW'(br_q) & pat_mask;
	assign cnt_idx  = op_read ? req_q.query_pattern : br_idx;
	assign size_w   = {{PNW{1'b0}}, 1'b1} << pos;
	assign cnt_addr = base_q + PIW'(cnt_idx);
	assign clr_addr = base_q + PIW'(clr_q);
	assign zc_bump  = ltp_pkg::bump(zc_rd_q);
	assign pc_bump  = ltp_pkg::bump(pc_rd_q);

	assign sts.op_read      = op_read;
	assign sts.hit          = cmp_v_q && (fa_rd_q == key);
	assign sts.miss         = !cmp_v_q && (scan_q >= used_q);
	assign sts.full         = (used_q == UW'(ltp_pkg::FRAGMENTS));
	assign sts.loop_hit     = pos_hit && (req_q.from_pc > req_q.to_pc);
	assign sts.pos_zero     = (pos == '0);
	assign sts.q_zero       = (req_q.query_jumps == '0);
	assign sts.q_bad        = (req_q.query_jumps > QW'(HJ)) ||
	                          ((req_q.query_pattern >> req_q.query_jumps) != '0);
	assign sts.region_valid = vrow_rd_q[rsel];
	assign sts.can_alloc    = ({1'b0, pool_next_q} + size_w) <= (PNW+1)'(ltp_pkg::POOL_ENTRIES);
	assign sts.clear_last   = (clr_q == pat_mask);
	assign sts.out_free     = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign res       = res_out_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			pool_next_q <= '0;
			scan_q      <= '0;
			cmp_v_q     <= 1'b0;
			hv_q        <= '0;
			br_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_q  <= '0;
				cmp_v_q <= 1'b0;
			end else if (cmd.scan) begin
				if (scan_q < used_q) begin
					scan_q  <= scan_q + 1'b1;
					cmp_v_q <= 1'b1;
				end else begin
					cmp_v_q <= 1'b0;
				end
			end
			if (cmd.create)
				used_q <= used_q + 1'b1;
			if (cmd.alloc)
				pool_next_q <= pool_next_q + size_w[PNW-1:0];
			if (cmd.shift) begin
				hv_q <= {hv_q[HD-2:0], 1'b1};
				br_q <= {br_q[HJ-2:0], branch};
			end
			if (cmd.finish)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			res_q <= '0;
		end
		if (cmd.scan) begin
			cmp_idx_q <= scan_q[SW-1:0];
			if (sts.hit) begin
				slot_q              <= cmp_idx_q;
				res_q.fragment_slot <= 8'(cmp_idx_q);
			end
		end
		if (cmd.create) begin
			slot_q              <= used_q[SW-1:0];
			res_q.fragment_slot <= 8'(used_q[SW-1:0]);
		end
		if (cmd.use_base)
			base_q <= base_rd_q;
		if (cmd.alloc) begin
			base_q <= pool_next_q[PIW-1:0];
			clr_q  <= '0;
		end
		if (cmd.clear)
			clr_q <= clr_q + 1'b1;
		if (cmd.zero_wr) begin
			res_q.loop_found <= 1'b1;
			res_q.count      <= 32'(zc_bump);
		end
		if (cmd.zero_res)
			res_q.count <= 32'(zc_rd_q);
		if (cmd.cnt_wr) begin
			res_q.loop_found   <= 1'b1;
			res_q.loop_jumps   <= 4'(pos);
			res_q.loop_pattern <= 8'(br_idx);
			res_q.count        <= 32'(pc_bump);
		end
		if (cmd.cnt_res)
			res_q.count <= 32'(pc_rd_q);
		if (cmd.set_status)
			res_q.status <= cmd.status_code;
		if (cmd.shift) begin
			hs_q[0] <= slot_q;
			for (int i = 1; i < HD; i++)
				hs_q[i] <= hs_q[i-1];
		end
		if (cmd.finish)
			res_out_q <= res_q;
	end

	// fragment address table
	always_ff @(posedge clk) begin
		if (cmd.create)
			fa_mem[used_q[SW-1:0]] <= req_q.to_pc;
		if (cmd.scan)
			fa_rd_q <= fa_mem[scan_q[SW-1:0]];
	end

	// zero-jump counters
	always_ff @(posedge clk) begin
		if (cmd.create)
			zc_mem[used_q[SW-1:0]] <= '0;
		else if (cmd.zero_wr)
			zc_mem[slot_q] <= zc_bump;
		if (cmd.meta)
			zc_rd_q <= zc_mem[slot_q];
	end

	// region valid rows, one bit per loop length
	always_ff @(posedge clk) begin
		if (cmd.create)
			vrow_mem[used_q[SW-1:0]] <= '0;
		else if (cmd.alloc)
			vrow_mem[slot_q] <= vrow_rd_q | (HJ'(1) << rsel);
		if (cmd.meta)
			vrow_rd_q <= vrow_mem[slot_q];
	end

	// region base addresses
	always_ff @(posedge clk) begin
		if (cmd.alloc)
			base_mem[{slot_q, rsel}] <= pool_next_q[PIW-1:0];
		if (cmd.meta)
			base_rd_q <= base_mem[{slot_q, rsel}];
	end

	// pattern counter pool
	always_ff @(posedge clk) begin
		if (cmd.clear)
			pc_mem[clr_addr] <= '0;
		else if (cmd.cnt_wr)
			pc_mem[cnt_addr] <= pc_bump;
		if (cmd.cnt_rd)
			pc_rd_q <= pc_mem[cnt_addr];
	end

endmodule

// ----- rtl/core/ltp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Loop trace profiler controller
// Sequences lookup, slot creation, region allocation and counter updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ltp_pkg::sts_t sts,
	output ltp_pkg::cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_SCAN   = 12'b0000_0000_0010,
		S_CREATE = 12'b0000_0000_0100,
		S_META   = 12'b0000_0000_1000,
		S_EVAL   = 12'b0000_0001_0000,
		S_ZWR    = 12'b0000_0010_0000,
		S_ALLOC  = 12'b0000_0100_0000,
		S_CLEAR  = 12'b0000_1000_0000,
		S_RDCNT  = 12'b0001_0000_0000,
		S_CWR    = 12'b0010_0000_0000,
		S_SHIFT  = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = S_META;
				end else if (sts.miss) begin
					if (sts.op_read) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ltp_pkg::ST_NOT_FOUND;
						state_d         = S_DONE;
					end else if (sts.full) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ltp_pkg::ST_TABLE_FULL;
						state_d         = S_DONE;
					end else begin
						state_d = S_CREATE;
					end
				end
			end
			S_CREATE: begin
				cmd.create = 1'b1;
				state_d    = S_META;
			end
			S_META: begin
				cmd.meta = 1'b1;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				if (sts.op_read) begin
					if (sts.q_zero) begin
						cmd.zero_res = 1'b1;
						state_d      = S_DONE;
					end else if (sts.q_bad) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ltp_pkg::ST_NOT_FOUND;
						state_d         = S_DONE;
					end else if (sts.region_valid) begin
						cmd.use_base = 1'b1;
						state_d      = S_RDCNT;
					end else begin
						state_d = S_DONE;
					end
				end else if (!sts.loop_hit) begin
					state_d = S_SHIFT;
				end else if (sts.pos_zero) begin
					state_d = S_ZWR;
				end else if (sts.region_valid) begin
					cmd.use_base = 1'b1;
					state_d      = S_RDCNT;
				end else if (sts.can_alloc) begin
					state_d = S_ALLOC;
				end else begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ltp_pkg::ST_POOL_FULL;
					state_d         = S_SHIFT;
				end
			end
			S_ZWR: begin
				cmd.zero_wr = 1'b1;
				state_d     = S_SHIFT;
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = S_CLEAR;
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last)
					state_d = S_RDCNT;
			end
			S_RDCNT: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_CWR;
			end
			S_CWR: begin
				if (sts.op_read) begin
					cmd.cnt_res = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.cnt_wr = 1'b1;
					state_d    = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- rtl/core/loop_trace_profiler_top.sv -----
// ----------------------------------------------------------------------------
// Loop trace profiler top level
// Counts backward-jump loops per fragment and branch pattern; answers reads.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------
//  request   | req_valid, req_stall | req (ltp_pkg::req_t): op, pcs, query
//  result    | res_valid, res_stall | res (ltp_pkg::res_t): one per request
//
//  Flow: one request at a time. The fragment table is scanned one entry per
//  cycle during lookup. The first loop of length n seen for a fragment
//  allocates a region and zeroes its 2^n pool counters, one per cycle.
//  Reset: asynchronous, clears fill counts and history; no clearing pass.
//  Stalls: a finished result waits in the output register while the next
//  request is already accepted and worked on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module loop_trace_profiler_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ltp_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_stall,
	output ltp_pkg::res_t res
);

	// controller <-> datapath bundles
	ltp_pkg::cmd_t cmd;
	ltp_pkg::sts_t sts;

	// sequencer: lookup, create, allocate, count, shift history
	ltp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// tables, counters, histories and the output register
	ltp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ----- rtl/core/ltp_checker.sv -----
// ----------------------------------------------------------------------------
// Loop trace profiler checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "loop_trace_profiler_top_macros.svh"

module ltp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_stall,
	input ltp_pkg::res_t res
);

	`LTP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
	`LTP_ASSERT_IMPL(a_full_clean, res_valid && res.status == ltp_pkg::ST_TABLE_FULL, !res.loop_found && res.count == '0 && res.fragment_slot == '0)
	`LTP_ASSERT_IMPL(a_noloop_clean, res_valid && !res.loop_found, res.loop_jumps == '0 && res.loop_pattern == '0)
	`LTP_ASSERT_IMPL(a_loop_counted, res_valid && res.loop_found, res.status == ltp_pkg::ST_OK && res.count != '0 && res.loop_jumps <= 4'd8)

endmodule

bind loop_trace_profiler_top ltp_checker u_ltp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
